@@ rtl/eau_pkg.sv @@
// ----------------------------------------------------------------------------
// Elementwise activation unit package
// Widths, pipeline depths, function codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package eau_pkg;

  // field widths
  localparam int ActionW = 4;
  localparam int SampleW = 16;
  localparam int SlopeW  = 18;
  localparam int ResultW = 32;

  // exponential unit
  localparam int ExpInW  = 18;   // argument s/256, up to twice the sample
  localparam int ExpW    = 62;   // e^y in Q.32, capped at 2^61
  localparam int HornerN = 12;   // terms of the e^r polynomial
  localparam int QuotW   = 32;   // sigmoid quotient bits

  // pipeline depths
  localparam int ExpLat  = 4 + 2 * HornerN + 1;
  localparam int DivLat  = QuotW + 1;
  localparam int PostLat = 5;
  localparam int SideLat = ExpLat + DivLat;
  localparam int TotLat  = SideLat + PostLat;

  // arithmetic constants
  localparam longint Log2eQ16 = 64'sd94548;
  localparam longint Ln2Q32   = 64'sd2977044472;
  localparam longint One32    = 64'sd4294967296;
  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;

  localparam logic signed [SlopeW-1:0] SlopeReset = 18'sd655;

  // function select codes
  typedef enum logic [ActionW-1:0] {
    ACT_IDENTITY = 4'd0,
    ACT_LINEAR   = 4'd1,
    ACT_SIGMOID  = 4'd2,
    ACT_RELU     = 4'd3,
    ACT_LEAKY    = 4'd4,
    ACT_PRELU    = 4'd5,
    ACT_ELU      = 4'd6,
    ACT_SINH     = 4'd7,
    ACT_COSH     = 4'd8,
    ACT_TANH     = 4'd9,
    ACT_SWISH    = 4'd10
  } act_e;

  // per-word control carried alongside the datapath
  typedef struct packed {
    logic [ActionW-1:0]        action;
    logic                      deriv;
    logic signed [SampleW-1:0] sample;
  } eau_side_t;

  // output queue entry
  typedef struct packed {
    logic [ResultW-1:0] result;
    logic               saturated;
  } eau_res_t;

endpackage

`default_nettype wire

@@ rtl/eau_if.sv @@
// ----------------------------------------------------------------------------
// Elementwise activation unit channels
// Valid/ready channels for input words, result words and the slope register.
// ----------------------------------------------------------------------------
`default_nettype none

interface eau_in_if import eau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ActionW-1:0]        action;
  logic                      derivative;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, action, derivative, sample, input ready);
  modport sink   (input valid, action, derivative, sample, output ready);
endinterface

interface eau_out_if import eau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ResultW-1:0] result;
  logic                      saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

interface eau_cfg_if import eau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SlopeW-1:0] slope;

  modport source (output valid, slope, input ready);
  modport sink   (input valid, slope, output ready);
endinterface

`default_nettype wire

@@ rtl/elementwise_activation_unit_top.sv @@
// ----------------------------------------------------------------------------
// Elementwise activation unit
// Path from input handshake to result valid: exp chain, 33-stage sigmoid
//   divider, five back-end stages, output queue.
// Throughput: one word per cycle; the pipeline stalls only when the
//   two-entry output queue is full and not being drained.
// Reset: clears valid bits and output queue, slope returns to 655.
// ----------------------------------------------------------------------------
`default_nettype none

module elementwise_activation_unit_top import eau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  eau_in_if.sink    in_i,
  eau_out_if.source out_o,
  eau_cfg_if.sink   cfg_i
);

  logic signed [SlopeW-1:0] slope_q;
  logic                     en, accept, push, pop;
  logic [TotLat-1:0]        vld_q;

  // slope register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= SlopeReset;
    end else if (cfg_i.valid) begin
      slope_q <= cfg_i.slope;
    end
  end

  // pipeline advance and valid bits
  logic [1:0] cnt_q;

  assign en          = (cnt_q != 2'd2) | out_o.ready;
  assign in_i.ready  = en;
  assign accept      = in_i.valid & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TotLat-2:0], accept};
    end
  end

  // exponential arguments
  logic signed [ExpInW-1:0] s18, arg_a, arg_b;

  always_comb begin
    s18   = ExpInW'(in_i.sample);
    arg_b = -s18;
    case (in_i.action)
      ACT_ELU, ACT_SINH, ACT_COSH: arg_a = s18;
      ACT_TANH:                    arg_a = -(s18 <<< 1);
      default:                     arg_a = -s18;
    endcase
  end

  // word control line alongside the datapath
  eau_side_t side_q [SideLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{action: in_i.action, deriv: in_i.derivative, sample: in_i.sample};
      for (int i = 1; i < SideLat; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // exponentials
  logic [ExpW-1:0] ea, eb;

  eau_exp u_exp_a (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg_a),
    .exp_o (ea)
  );

  eau_exp u_exp_b (
    .clk_i (clk_i),
    .en_i  (en),
    .arg_i (arg_b),
    .exp_o (eb)
  );

  // sigmoid quotient
  logic [QuotW-1:0] quo;

  eau_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .exp_i (ea),
    .quo_o (quo)
  );

  // exponentials delayed to meet the quotient
  logic [ExpW-1:0] ead_q [DivLat];
  logic [ExpW-1:0] ebd_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ead_q[0] <= ea;
      ebd_q[0] <= eb;
      for (int i = 1; i < DivLat; i++) begin
        ead_q[i] <= ead_q[i-1];
        ebd_q[i] <= ebd_q[i-1];
      end
    end
  end

  // back end
  logic signed [ResultW-1:0] res;
  logic                      sat;

  eau_post u_post (
    .clk_i       (clk_i),
    .en_i        (en),
    .side_i      (side_q[SideLat-1]),
    .ea_i        (ead_q[DivLat-1]),
    .eb_i        (ebd_q[DivLat-1]),
    .quo_i       (quo),
    .slope_i     (slope_q),
    .result_o    (res),
    .saturated_o (sat)
  );

  // two-entry output queue
  eau_res_t fifo_q [2];
  logic     wr_ptr_q, rd_ptr_q;

  assign push = en & vld_q[TotLat-1];
  assign pop  = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{result: res, saturated: sat};
    end
  end

  assign out_o.valid     = cnt_q != 2'd0;
  assign out_o.result    = fifo_q[rd_ptr_q].result;
  assign out_o.saturated = fifo_q[rd_ptr_q].saturated;

endmodule

`default_nettype wire

@@ rtl/eau_exp.sv @@
// ----------------------------------------------------------------------------
// Exponential pipeline
// e^(s/256) in Q.32: range reduction by ln2, Horner polynomial, final shift.
// ----------------------------------------------------------------------------
`default_nettype none

module eau_exp import eau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ExpInW-1:0] arg_i,
  output logic [ExpW-1:0]          exp_o
);

  localparam int KW = 11;
  localparam int RW = 46;
  localparam logic [30:0] POne = 31'd1 << 30;
  localparam logic [ExpW-1:0] ExpCap = ExpW'(64'd1 << 61);

  logic signed [ExpInW-1:0] arg_q, arg2_q;
  logic signed [35:0]       kp_q;
  logic signed [KW-1:0]     k_d, k_q;
  logic signed [RW-1:0]     r_d, r_q;
  logic [29:0]              r30_d, r30_q;
  logic signed [KW:0]       sh_d, sh_q;

  // range reduction: k from log2(e), remainder r
  assign k_d = KW'(kp_q >>> 24);
  assign r_d = (RW'(arg2_q) <<< 24) - RW'(k_d) * RW'(Ln2Q32);

  // bring remainder into [0, ln2)
  always_comb begin
    logic signed [RW-1:0] r1, r2;
    logic signed [KW-1:0] k1, k2;
    r1 = r_q;
    k1 = k_q;
    if (r_q < 0) begin
      k1 = k_q - KW'(1);
      r1 = r_q + RW'(Ln2Q32);
    end
    r2 = r1;
    k2 = k1;
    if (r1 >= RW'(Ln2Q32)) begin
      k2 = k1 + KW'(1);
      r2 = r1 - RW'(Ln2Q32);
    end
    r30_d = r2[31:2];
    sh_d  = (KW+1)'(k2) + (KW+1)'(2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arg_q  <= arg_i;
      kp_q   <= 36'(arg_q) * 36'(Log2eQ16);
      arg2_q <= arg_q;
      k_q    <= k_d;
      r_q    <= r_d;
      r30_q  <= r30_d;
      sh_q   <= sh_d;
    end
  end

  // horner chain, two stages a term: multiply, then divide by the term index
  logic [60:0]        prod_q [HornerN];
  logic signed [KW:0] sa_q   [HornerN];
  logic [30:0]        p_q    [HornerN];
  logic signed [KW:0] sb_q   [HornerN];
  logic [29:0]        ra_q   [HornerN-1];
  logic [29:0]        rb_q   [HornerN-1];

  for (genvar j = 0; j < HornerN; j++) begin : g_step
    localparam int N = HornerN - j;
    localparam logic [35:0] RecipM = 36'(((64'd1 << 35) + 64'(N) - 64'd1) / 64'(N));
    logic [30:0]        p_in;
    logic [29:0]        r_in;
    logic signed [KW:0] s_in;
    logic [30:0]        quo;
    logic [66:0]        qm;

    if (j == 0) begin : g_head
      assign p_in = POne;
      assign r_in = r30_q;
      assign s_in = sh_q;
    end else begin : g_tail
      assign p_in = p_q[j-1];
      assign r_in = rb_q[j-1];
      assign s_in = sb_q[j-1];
    end

    // exact floor division by a small constant via reciprocal
    assign quo = prod_q[j][60:30];
    assign qm  = 67'(quo) * 67'(RecipM);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[j] <= 61'(r_in) * 61'(p_in);
        sa_q[j]   <= s_in;
        p_q[j]    <= POne + 31'(qm >> 35);
        sb_q[j]   <= sa_q[j];
      end
    end

    if (j < HornerN - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ra_q[j] <= r_in;
          rb_q[j] <= ra_q[j];
        end
      end
    end
  end

  // scale by 2^(k+2) with cap and rounding
  logic [ExpW-1:0] e_d, e_q;

  always_comb begin
    logic [30:0]        pf;
    logic signed [KW:0] shf, negsh;
    logic [63:0]        lft, rt;
    logic [5:0]         nsh;
    pf    = p_q[HornerN-1];
    shf   = sb_q[HornerN-1];
    negsh = -shf;
    lft   = '0;
    rt    = '0;
    nsh   = '0;
    e_d   = '0;
    if (shf > 30) begin
      e_d = ExpCap;
    end else if (shf >= 0) begin
      lft = 64'(pf) << shf[4:0];
      e_d = (lft > 64'(ExpCap)) ? ExpCap : ExpW'(lft);
    end else if (negsh < 40) begin
      nsh = 6'(negsh);
      rt  = (64'(pf) + (64'd1 << (nsh - 6'd1))) >> nsh;
      e_d = ExpW'(rt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  assign exp_o = e_q;

endmodule

`default_nettype wire

@@ rtl/eau_div.sv @@
// ----------------------------------------------------------------------------
// Sigmoid divider
// Rounded 2^63 / (2^32 + e), restoring division one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eau_div import eau_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ExpW-1:0]  exp_i,
  output logic [QuotW-1:0] quo_o
);

  logic [63:0]      rem_q [QuotW];
  logic [62:0]      den_q [QuotW];
  logic [QuotW-1:0] quo_q [QuotW];
  logic [62:0]      den_d;
  logic [63:0]      num_d;

  // denominator and numerator with half-divisor rounding term
  assign den_d = (63'd1 << 32) + 63'(exp_i);
  assign num_d = (64'd1 << 63) + 64'(den_d >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_d;
      den_q[0] <= den_d;
    end
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_bit
    localparam int B = QuotW - 1 - s;
    logic             ge;
    logic [QuotW-1:0] qprev;

    assign ge = (rem_q[s] >> B) >= 64'(den_q[s]);

    if (s == 0) begin : g_first
      assign qprev = '0;
    end else begin : g_next
      assign qprev = quo_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {qprev[QuotW-2:0], ge};
      end
    end

    if (s < QuotW - 1) begin : g_rem
      logic [63:0] nrem;
      assign nrem = ge ? rem_q[s] - (64'(den_q[s]) << B) : rem_q[s];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1] <= nrem;
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  assign quo_o = quo_q[QuotW-1];

endmodule

`default_nettype wire

@@ rtl/eau_post.sv @@
// ----------------------------------------------------------------------------
// Activation back end
// Sigmoid slope, shared product, function select, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module eau_post import eau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  eau_side_t                side_i,
  input  logic [ExpW-1:0]          ea_i,
  input  logic [ExpW-1:0]          eb_i,
  input  logic [QuotW-1:0]         quo_i,
  input  logic signed [SlopeW-1:0] slope_i,
  output logic signed [ResultW-1:0] result_o,
  output logic                     saturated_o
);

  localparam logic [32:0] SgOne = 33'd1 << 32;

  // stage a: sigmoid and its product with one minus itself
  eau_side_t       sda_q, sdb_q, sdc_q;
  logic [32:0]     sg_a, sga_q, sgb_q, sgc_q;
  logic [63:0]     sp_q;
  logic [ExpW-1:0] eaa_q, eba_q, eab_q, ebb_q, eac_q, ebc_q;
  logic [31:0]     dsg_d, dsg_q, dsc_q;

  assign sg_a  = {quo_i, 1'b0};
  assign dsg_d = 32'((sp_q + (64'd1 << 31)) >> 32);

  // stage c: one shared signed product
  logic signed [17:0] opa;
  logic signed [34:0] opb, eo;
  logic signed [52:0] mp_q;

  always_comb begin
    eo  = $signed({1'b0, eab_q[33:0]});
    opa = slope_i;
    opb = 35'(sdb_q.sample);
    case (sdb_q.action)
      ACT_ELU: begin
        opb = sdb_q.deriv ? eo : eo - 35'(One32);
      end
      ACT_SWISH: begin
        opa = 18'(sdb_q.sample);
        opb = sdb_q.deriv ? $signed({3'b0, dsg_q}) : $signed({2'b0, sgb_q});
      end
      default: begin
        opa = slope_i;
      end
    endcase
  end

  // stage d: pick the Q.32 value
  logic signed [63:0] v_d, v_q;
  logic               n17_d, n17_q;

  always_comb begin
    logic signed [63:0] x32, cx, c16, one, sg64, ds64, ea64, eb64, rnd16, rnd8;
    logic               nonpos;
    x32    = 64'(sdc_q.sample) <<< 24;
    cx     = 64'(mp_q) <<< 8;
    c16    = 64'(slope_i) <<< 16;
    one    = 64'(One32);
    sg64   = $signed(64'(sgc_q));
    ds64   = $signed(64'(dsc_q));
    ea64   = $signed(64'(eac_q));
    eb64   = $signed(64'(ebc_q));
    rnd16  = (64'(mp_q) + 64'sd32768) >>> 16;
    rnd8   = (64'(mp_q) + 64'sd128) >>> 8;
    nonpos = sdc_q.sample <= 0;
    n17_d  = 1'b0;
    v_d    = '0;
    case (sdc_q.action)
      ACT_IDENTITY: v_d = x32;
      ACT_LINEAR:   v_d = sdc_q.deriv ? one : x32;
      ACT_SIGMOID:  v_d = sdc_q.deriv ? ds64 : sg64;
      ACT_RELU: begin
        if (sdc_q.deriv) v_d = nonpos ? 64'sd0 : one;
        else             v_d = nonpos ? 64'sd0 : x32;
      end
      ACT_LEAKY: begin
        if (sdc_q.deriv) v_d = nonpos ? c16 : one;
        else             v_d = (cx > x32) ? cx : x32;
      end
      ACT_PRELU: begin
        if (sdc_q.deriv) v_d = nonpos ? c16 : one;
        else             v_d = nonpos ? cx : x32;
      end
      ACT_ELU: begin
        if (nonpos) v_d = rnd16;
        else        v_d = sdc_q.deriv ? one : x32;
      end
      ACT_SINH, ACT_COSH: begin
        n17_d = 1'b1;
        if ((sdc_q.action == ACT_SINH) == sdc_q.deriv) v_d = ea64 + eb64;
        else                                           v_d = ea64 - eb64;
      end
      ACT_TANH: v_d = sdc_q.deriv ? (ds64 <<< 2) : (sg64 <<< 1) - one;
      ACT_SWISH: v_d = sdc_q.deriv ? sg64 + rnd8 : rnd8;
      default: v_d = '0;
    endcase
  end

  // stage e: round to Q.16 and clamp
  logic signed [ResultW-1:0] res_d, res_q;
  logic                      sat_d, sat_q;

  always_comb begin
    logic signed [63:0] t;
    if (n17_q) t = (v_q + 64'sd65536) >>> 17;
    else       t = (v_q + 64'sd32768) >>> 16;
    sat_d = 1'b0;
    res_d = ResultW'(t);
    if (t > Int32Max) begin
      res_d = ResultW'(Int32Max);
      sat_d = 1'b1;
    end else if (t < Int32Min) begin
      res_d = ResultW'(Int32Min);
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q  <= 64'(sg_a) * 64'(SgOne - sg_a);
      sga_q <= sg_a;
      eaa_q <= ea_i;
      eba_q <= eb_i;
      sda_q <= side_i;

      dsg_q <= dsg_d;
      sgb_q <= sga_q;
      eab_q <= eaa_q;
      ebb_q <= eba_q;
      sdb_q <= sda_q;

      mp_q  <= 53'(opa) * 53'(opb);
      dsc_q <= dsg_q;
      sgc_q <= sgb_q;
      eac_q <= eab_q;
      ebc_q <= ebb_q;
      sdc_q <= sdb_q;

      v_q   <= v_d;
      n17_q <= n17_d;

      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign result_o    = res_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

@@ dv/tb_elementwise_activation_unit_top.sv @@
// ----------------------------------------------------------------------------
// Elementwise activation unit testbench
// Drives sample words through the valid/ready channels under random idling
// on both sides and checks every result word against a fixed-point predictor
// of each activation and derivative, over several slope settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_elementwise_activation_unit_top;
  import eau_pkg::*;

  localparam int  TimeoutCycles = 400000;
  localparam int  DrainCycles   = TotLat + 20;
  localparam int  WordsPerPhase = 390;
  localparam logic [ActionW-1:0] ActLast = 4'(ACT_SWISH);

  typedef struct {
    logic [ActionW-1:0]        action;
    logic                      deriv;
    logic signed [SampleW-1:0] sample;
  } sample_word_t;

  typedef struct {
    logic [ResultW-1:0] result;
    logic               saturated;
  } act_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  eau_in_if  in_if ();
  eau_out_if out_if ();
  eau_cfg_if cfg_if ();

  elementwise_activation_unit_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  sample_word_t            word_q[$];
  act_result_t             result_q[$];
  logic signed [SlopeW-1:0] slope_c = SlopeReset;
  bit                      quiet = 1'b0;
  int                      errors = 0;
  int                      cycles = 0;

  // e^(s/256) in Q.32, capped at 2^61
  function automatic longint unsigned exp_q32(int s);
    longint          k, r, sh;
    longint unsigned r30, p;
    int              n;
    k = (longint'(s) * Log2eQ16) >>> 24;
    r = longint'(s) * 16777216 - k * Ln2Q32;
    if (r < 0) begin
      k--;
      r += Ln2Q32;
    end
    if (r >= Ln2Q32) begin
      k++;
      r -= Ln2Q32;
    end
    r30 = longint'(unsigned'(r)) >> 2;
    r30 = r >> 2;
    p = 64'd1 << 30;
    for (n = 12; n >= 1; n--) p = (64'd1 << 30) + ((r30 * p) >> 30) / n;
    sh = k + 2;
    if (sh > 30) return 64'd1 << 61;
    if (sh >= 0) begin
      p = p << sh;
      return (p > (64'd1 << 61)) ? (64'd1 << 61) : p;
    end
    if (-sh >= 40) return 0;
    n = int'(-sh);
    return (p + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic longint sigmoid_q32(int s);
    longint unsigned den, q;
    den = (64'd1 << 32) + exp_q32(-s);
    q = ((64'd1 << 63) + den / 2) / den;
    return longint'(q * 2);
  endfunction

  function automatic longint dsigmoid_q32(longint sg);
    longint unsigned u, prod;
    u = sg;
    prod = u * ((64'd1 << 32) - u);
    return longint'((prod + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint round_shift(longint a, int n);
    return (a + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // expected result word for one sample word at the current slope
  function automatic act_result_t activation_expect(sample_word_t w);
    act_result_t res;
    longint c, s, x32, cx, v, r, sg, e;
    int n;
    c = slope_c;
    s = w.sample;
    x32 = s * 16777216;
    cx = c * s * 256;
    v = 0;
    n = 16;
    case (w.action)
      ACT_IDENTITY: v = x32;
      ACT_LINEAR:   v = w.deriv ? One32 : x32;
      ACT_SIGMOID: begin
        sg = sigmoid_q32(int'(s));
        v = w.deriv ? dsigmoid_q32(sg) : sg;
      end
      ACT_RELU: v = w.deriv ? ((s <= 0) ? 0 : One32) : ((s > 0) ? x32 : 0);
      ACT_LEAKY: begin
        if (w.deriv) v = (s <= 0) ? c * 65536 : One32;
        else v = (cx > x32) ? cx : x32;
      end
      ACT_PRELU: begin
        if (w.deriv) v = (s <= 0) ? c * 65536 : One32;
        else v = (s <= 0) ? cx : x32;
      end
      ACT_ELU: begin
        if (s <= 0) begin
          e = longint'(exp_q32(int'(s)));
          v = w.deriv ? round_shift(c * e, 16) : round_shift(c * (e - One32), 16);
        end else begin
          v = w.deriv ? One32 : x32;
        end
      end
      ACT_SINH, ACT_COSH: begin
        n = 17;
        // sinh' is cosh and cosh' is sinh
        if ((w.action == ACT_SINH) == w.deriv)
          v = longint'(exp_q32(int'(s)) + exp_q32(int'(-s)));
        else v = longint'(exp_q32(int'(s))) - longint'(exp_q32(int'(-s)));
      end
      ACT_TANH: begin
        sg = sigmoid_q32(int'(2 * s));
        v = w.deriv ? 4 * dsigmoid_q32(sg) : 2 * sg - One32;
      end
      ACT_SWISH: begin
        sg = sigmoid_q32(int'(s));
        v = w.deriv ? sg + round_shift(s * dsigmoid_q32(sg), 8)
                    : round_shift(s * sg, 8);
      end
      default: v = 0;
    endcase
    r = round_shift(v, n);
    res.saturated = 1'b0;
    if (r > Int32Max) begin
      r = Int32Max;
      res.saturated = 1'b1;
    end
    if (r < Int32Min) begin
      r = Int32Min;
      res.saturated = 1'b1;
    end
    res.result = r[31:0];
    return res;
  endfunction

  // word driver with random idle bursts
  int in_gap = 0;
  always @(posedge clk_i) begin
    sample_word_t w;
    logic nxt_valid;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        w.action = in_if.action;
        w.deriv  = in_if.derivative;
        w.sample = in_if.sample;
        result_q.push_back(activation_expect(w));
      end
      if (!in_if.valid || in_if.ready) begin
        nxt_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          in_if.action     <= w.action;
          in_if.derivative <= w.deriv;
          in_if.sample     <= w.sample;
          nxt_valid = 1'b1;
          if (!quiet && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 11);
        end
        in_if.valid <= nxt_valid;
      end
    end
  end

  // result monitor with random stalls
  int out_gap = 0;
  always @(posedge clk_i) begin
    act_result_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word: actual result %h saturated %b",
                   $time, out_if.result, out_if.saturated);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_if.result !== exp_r.result) begin
            $display("%0t: result mismatch: expected %h actual %h",
                     $time, exp_r.result, out_if.result);
            errors++;
          end
          if (out_if.saturated !== exp_r.saturated) begin
            $display("%0t: saturated mismatch: expected %b actual %b",
                     $time, exp_r.saturated, out_if.saturated);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TimeoutCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_slope(logic signed [SlopeW-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.slope <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_if.ready) break;
    end
    slope_c = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic add_word(logic [ActionW-1:0] act, logic d, logic signed [SampleW-1:0] s);
    sample_word_t w;
    w.action = act;
    w.deriv  = d;
    w.sample = s;
    word_q.push_back(w);
  endtask

  task automatic add_random_words(int count);
    logic [ActionW-1:0]        act;
    logic signed [SampleW-1:0] s;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, ActLast));
      case ($urandom_range(0, 3))
        0: s = 16'($urandom);
        1: s = 16'($urandom_range(0, 2048)) - 16'sd1024;
        2: s = 16'($urandom_range(2700, 3000)) * (($urandom & 1) ? 1 : -1);
        default: s = 16'($urandom_range(0, 16383)) - 16'sd8192;
      endcase
      add_word(act, 1'($urandom), s);
    end
  endtask

  task automatic wait_idle();
    wait (word_q.size() == 0 && !in_if.valid && result_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic signed [SlopeW-1:0] slopes[4];
    in_if.valid      = 1'b0;
    in_if.action     = '0;
    in_if.derivative = 1'b0;
    in_if.sample     = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.slope     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every code incl. unknown ones, at alternating extremes, reset slope
    for (int a = 0; a < 16; a++)
      add_word(4'(a), 1'(a), (a % 2) ? 16'sh7fff : 16'sh8000);
    // identity ignores the derivative flag
    add_word(ACT_IDENTITY, 1'b1, 16'sd1000);
    // sinh and cosh around the saturation point
    add_word(ACT_SINH, 1'b0, 16'sd2839);
    add_word(ACT_SINH, 1'b0, 16'sd2841);
    add_word(ACT_COSH, 1'b0, -16'sd2841);
    add_word(ACT_COSH, 1'b1, -16'sd2900);
    add_word(ACT_ELU, 1'b1, 16'sd0);
    add_word(ACT_LEAKY, 1'b0, -16'sd1);
    add_random_words(WordsPerPhase - 23);
    wait_idle();

    slopes = '{-18'sd131072, 18'sd131071, 18'sd0, 18'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      write_slope(slopes[ph]);
      if (ph == 3) quiet = 1'b1;
      add_word(ACT_LEAKY, 1'b0, 16'sh8000);
      add_word(ACT_PRELU, 1'b1, 16'sh8000);
      add_word(ACT_ELU, 1'b0, 16'sh8000);
      add_random_words(WordsPerPhase - 3);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
